>>> src/mbo_pkg.sv
`default_nettype none

package mbo_pkg;

  localparam int COUNT_W    = 32;
  localparam int POS_W      = 48;
  localparam int HEAD_W     = 40;
  localparam int CFG_W      = 24;
  localparam int CFG_ADDR_W = 1;

  localparam int DSUM_W     = COUNT_W + 2;
  localparam int PROD_W     = DSUM_W + CFG_W;
  localparam int TMAG_W     = PROD_W - 1;
  localparam int XS_W       = PROD_W + 1;
  localparam int MAGCAP_W   = HEAD_W + 1;
  localparam int DPHI_W     = MAGCAP_W + 2;
  localparam int HS_W       = DPHI_W + 1;
  localparam int RAD_SHIFT  = 16;
  localparam int DEG_K_W    = 30;
  localparam int DEG_SHIFT  = 24;
  localparam int DEG_PROD_W = HEAD_W + DEG_K_W;
  localparam int REM_W      = POS_W + 2;
  localparam int CNT_W      = 6;

  localparam logic [CFG_W-1:0]   MM_PER_COUNT_RST = 24'd65536;
  localparam logic [CFG_W-1:0]   RAD_PER_MM_RST   = 24'd41943;
  localparam logic [DEG_K_W-1:0] DEG_PER_RAD_Q24  = 30'd961263669;

  localparam logic [CFG_ADDR_W-1:0] CFG_MM_PER_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RAD_PER_MM   = 1'b1;

  localparam logic OP_RESET = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]  distance;
    logic [POS_W-1:0]  heading_deg;
    logic [HEAD_W-1:0] heading_rad;
    logic [POS_W-1:0]  y_pos;
    logic [POS_W-1:0]  x_pos;
  } mbo_result_t;

endpackage

`default_nettype wire

>>> src/mecanum_body_odometry_unit.sv
`default_nettype none

// Mecanum body odometry. Each input beat carries four absolute wheel counts; the unit
// forms wrapping deltas, scales them by mm_per_count, applies the mecanum forward
// kinematics and adds the motion to saturating x, y and heading accumulators. Every
// input beat gives exactly one output beat with x, y, heading in radians and degrees,
// and the distance sqrt(x^2 + y^2). A beat with op set, and the first beat after reset,
// only stores the counts, clears the accumulators and returns ok low with zero data.
// An update runs bit-serial scaling by mm_per_count, then a bit-serial sum of squares
// (the rad_per_mm product runs beside it) and then a square root that retires two
// radicand bits per cycle (the degree conversion runs beside it).
// The output register holds a finished beat while the next input is taken.
module mecanum_body_odometry_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // front_right_count, front_left_count, rear_left_count, rear_right_count
  input  wire logic [4*mbo_pkg::COUNT_W-1:0]         s_axis_tdata,
  // op
  input  wire logic [0:0]                            s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // x_pos, y_pos, heading_rad, heading_deg, distance
  output logic [$bits(mbo_pkg::mbo_result_t)-1:0]    m_axis_tdata,
  // ok
  output logic [0:0]                                 m_axis_tuser,
  input  wire logic                                  cfg_we_i,
  input  wire logic [mbo_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  wire logic [mbo_pkg::CFG_W-1:0]             cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_SQLD = 3'd4;
  localparam logic [2:0] ST_SQR  = 3'd5;
  localparam logic [2:0] ST_ROOT = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  localparam int COUNT_W    = mbo_pkg::COUNT_W;
  localparam int POS_W      = mbo_pkg::POS_W;
  localparam int HEAD_W     = mbo_pkg::HEAD_W;
  localparam int CFG_W      = mbo_pkg::CFG_W;
  localparam int DSUM_W     = mbo_pkg::DSUM_W;
  localparam int PROD_W     = mbo_pkg::PROD_W;
  localparam int TMAG_W     = mbo_pkg::TMAG_W;
  localparam int XS_W       = mbo_pkg::XS_W;
  localparam int MAGCAP_W   = mbo_pkg::MAGCAP_W;
  localparam int DPHI_W     = mbo_pkg::DPHI_W;
  localparam int HS_W       = mbo_pkg::HS_W;
  localparam int RAD_SHIFT  = mbo_pkg::RAD_SHIFT;
  localparam int DEG_K_W    = mbo_pkg::DEG_K_W;
  localparam int DEG_SHIFT  = mbo_pkg::DEG_SHIFT;
  localparam int DEG_PROD_W = mbo_pkg::DEG_PROD_W;
  localparam int REM_W      = mbo_pkg::REM_W;
  localparam int CNT_W      = mbo_pkg::CNT_W;
  localparam int DM_W       = TMAG_W + CFG_W;

  function automatic logic [POS_W-1:0] sat_pos(input logic [XS_W-1:0] v);
    logic fits;
    fits = (&v[XS_W-1:POS_W-1]) || !(|v[XS_W-1:POS_W-1]);
    if (fits) begin
      return v[POS_W-1:0];
    end
    return v[XS_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

  function automatic logic [HEAD_W-1:0] sat_head(input logic [HS_W-1:0] v);
    logic fits;
    fits = (&v[HS_W-1:HEAD_W-1]) || !(|v[HS_W-1:HEAD_W-1]);
    if (fits) begin
      return v[HEAD_W-1:0];
    end
    return v[HS_W-1] ? {1'b1, {(HEAD_W-1){1'b0}}} : {1'b0, {(HEAD_W-1){1'b1}}};
  endfunction

  logic [2:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    primed_q;
  logic                    out_valid_q, out_valid_d;
  logic [CFG_W-1:0]        mpc_q, rpm_q;

  logic                    out_ok_q;
  mbo_pkg::mbo_result_t    out_data_q;
  logic                    ok_q;

  logic [COUNT_W-1:0]        last_q [4];
  logic signed [COUNT_W-1:0] delta_q [4];
  logic signed [DSUM_W-1:0]  mx_q, my_q, mt_q;
  logic signed [PROD_W-1:0]  px_q, py_q, pt_q;
  logic [CFG_W-1:0]          mbits_q;

  logic signed [POS_W-1:0]   x_q, y_q;
  logic signed [HEAD_W-1:0]  h_q;
  logic signed [POS_W-1:0]   deg_q;

  logic [TMAG_W-1:0]         dm_a_q, dm_hi_q;
  logic [CFG_W-1:0]          dm_lo_q, dm_b_q;
  logic                      dm_neg_q;
  logic signed [DPHI_W-1:0]  dphi_q;

  logic [POS_W-1:0]          ax_q, ay_q, by_q, sq_hi_q, sq_lo_q;
  logic [REM_W-1:0]          rem_q;
  logic [POS_W-1:0]          root_q;

  logic [HEAD_W-1:0]         ga_q, g_hi_q;
  logic [DEG_K_W-1:0]        g_lo_q, gb_q;
  logic                      g_neg_q;

  logic                      accept, eff_rst, out_free, out_load;
  logic [COUNT_W-1:0]        cur [4];
  logic [PROD_W-1:0]         px_next, py_next, pt_next;
  logic [XS_W-1:0]           x_sum, y_sum;
  logic [TMAG_W:0]           dm_s;
  logic [DM_W-1:0]           dm_full;
  logic [DM_W-RAD_SHIFT-1:0] dm_rnd;
  logic                      dm_big;
  logic [MAGCAP_W:0]         dm_mag;
  logic [DPHI_W-1:0]         dphi_val;
  logic [HS_W-1:0]           h_sum;
  logic [POS_W:0]            sq_s;
  logic [REM_W-1:0]          rem_sh, trial;
  logic [REM_W:0]            diff;
  logic                      ge;
  logic [HEAD_W:0]           g_s;
  logic [DEG_PROD_W-1:0]     g_full;
  logic [DEG_PROD_W-DEG_SHIFT-1:0] g_rnd;
  logic [POS_W-1:0]          deg_val;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign eff_rst  = !primed_q || (s_axis_tuser[0] == mbo_pkg::OP_RESET);
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_FIN) && out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cur[i] = s_axis_tdata[i*COUNT_W +: COUNT_W];
    end
  end

  assign px_next = {px_q[PROD_W-2:0], 1'b0} + (mbits_q[CFG_W-1] ? PROD_W'(mx_q) : '0);
  assign py_next = {py_q[PROD_W-2:0], 1'b0} + (mbits_q[CFG_W-1] ? PROD_W'(my_q) : '0);
  assign pt_next = {pt_q[PROD_W-2:0], 1'b0} + (mbits_q[CFG_W-1] ? PROD_W'(mt_q) : '0);

  assign x_sum = XS_W'(x_q) + XS_W'($signed(px_q[PROD_W-1:2])) + XS_W'(px_q[1]);
  assign y_sum = XS_W'(y_q) + XS_W'($signed(py_q[PROD_W-1:2])) + XS_W'(py_q[1]);

  assign dm_s     = {1'b0, dm_hi_q} + (dm_b_q[0] ? {1'b0, dm_a_q} : '0);
  assign dm_full  = {dm_hi_q, dm_lo_q};
  assign dm_rnd   = dm_full[DM_W-1:RAD_SHIFT];
  assign dm_big   = |dm_rnd[DM_W-RAD_SHIFT-1:MAGCAP_W];
  assign dm_mag   = dm_big ? {1'b1, {MAGCAP_W{1'b0}}} : {1'b0, dm_rnd[MAGCAP_W-1:0]};
  assign dphi_val = dm_neg_q ? -DPHI_W'(dm_mag) : DPHI_W'(dm_mag);
  assign h_sum    = HS_W'(h_q) + HS_W'(dphi_q);

  assign sq_s = {1'b0, sq_hi_q} + (sq_lo_q[0] ? {1'b0, ax_q} : '0)
              + (by_q[0] ? {1'b0, ay_q} : '0);

  assign rem_sh = {rem_q[POS_W-1:0], sq_hi_q[POS_W-1:POS_W-2]};
  assign trial  = {root_q, 2'b01};
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};
  assign ge     = !diff[REM_W];

  assign g_s     = {1'b0, g_hi_q} + (gb_q[0] ? {1'b0, ga_q} : '0);
  assign g_full  = {g_hi_q, g_lo_q};
  assign g_rnd   = g_full[DEG_PROD_W-1:DEG_SHIFT];
  assign deg_val = g_neg_q ? -POS_W'(g_rnd) : POS_W'(g_rnd);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = eff_rst ? ST_FIN : ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_MUL;
        cnt_d   = '0;
      end
      ST_MUL: begin
        if (cnt_q == CNT_W'(CFG_W - 1)) begin
          state_d = ST_ACC;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ACC: begin
        state_d = ST_SQLD;
      end
      ST_SQLD: begin
        state_d = ST_SQR;
        cnt_d   = '0;
      end
      ST_SQR: begin
        if (cnt_q == CNT_W'(POS_W - 1)) begin
          state_d = ST_ROOT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ROOT: begin
        if (cnt_q == CNT_W'(POS_W - 1)) begin
          state_d = ST_FIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      mpc_q       <= mbo_pkg::MM_PER_COUNT_RST;
      rpm_q       <= mbo_pkg::RAD_PER_MM_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        primed_q <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          mbo_pkg::CFG_MM_PER_COUNT: mpc_q <= cfg_wdata_i;
          mbo_pkg::CFG_RAD_PER_MM:   rpm_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ok_q <= !eff_rst;
          for (int i = 0; i < 4; i++) begin
            last_q[i]  <= cur[i];
            delta_q[i] <= cur[i] - last_q[i];
          end
          if (eff_rst) begin
            x_q    <= '0;
            y_q    <= '0;
            h_q    <= '0;
            deg_q  <= '0;
            root_q <= '0;
          end
        end
      end
      ST_PREP: begin
        mx_q <= DSUM_W'(delta_q[0]) + DSUM_W'(delta_q[1])
              + DSUM_W'(delta_q[2]) + DSUM_W'(delta_q[3]);
        my_q <= DSUM_W'(delta_q[0]) - DSUM_W'(delta_q[1])
              + DSUM_W'(delta_q[2]) - DSUM_W'(delta_q[3]);
        mt_q <= DSUM_W'(delta_q[0]) - DSUM_W'(delta_q[1])
              - DSUM_W'(delta_q[2]) + DSUM_W'(delta_q[3]);
        px_q    <= '0;
        py_q    <= '0;
        pt_q    <= '0;
        mbits_q <= mpc_q;
      end
      ST_MUL: begin
        px_q    <= px_next;
        py_q    <= py_next;
        pt_q    <= pt_next;
        mbits_q <= {mbits_q[CFG_W-2:0], 1'b0};
      end
      ST_ACC: begin
        x_q      <= sat_pos(x_sum);
        y_q      <= sat_pos(y_sum);
        dm_a_q   <= TMAG_W'(pt_q[PROD_W-1] ? -pt_q : pt_q);
        dm_neg_q <= pt_q[PROD_W-1];
        dm_hi_q  <= TMAG_W'(1) << (RAD_SHIFT - 1);
        dm_b_q   <= rpm_q;
      end
      ST_SQLD: begin
        ax_q    <= x_q[POS_W-1] ? -x_q : x_q;
        ay_q    <= y_q[POS_W-1] ? -y_q : y_q;
        sq_lo_q <= x_q[POS_W-1] ? -x_q : x_q;
        by_q    <= y_q[POS_W-1] ? -y_q : y_q;
        sq_hi_q <= '0;
        rem_q   <= '0;
        root_q  <= '0;
      end
      ST_SQR: begin
        sq_hi_q <= sq_s[POS_W:1];
        sq_lo_q <= {sq_s[0], sq_lo_q[POS_W-1:1]};
        by_q    <= {1'b0, by_q[POS_W-1:1]};
        if (cnt_q < CNT_W'(CFG_W)) begin
          dm_hi_q <= dm_s[TMAG_W:1];
          dm_lo_q <= {dm_s[0], dm_lo_q[CFG_W-1:1]};
          dm_b_q  <= {1'b0, dm_b_q[CFG_W-1:1]};
        end
        if (cnt_q == CNT_W'(CFG_W)) begin
          dphi_q <= dphi_val;
        end
        if (cnt_q == CNT_W'(CFG_W + 1)) begin
          h_q <= sat_head(h_sum);
        end
        if (cnt_q == CNT_W'(CFG_W + 2)) begin
          ga_q    <= h_q[HEAD_W-1] ? -h_q : h_q;
          g_neg_q <= h_q[HEAD_W-1];
          g_hi_q  <= HEAD_W'(1) << (DEG_SHIFT - 1);
          gb_q    <= mbo_pkg::DEG_PER_RAD_Q24;
        end
      end
      ST_ROOT: begin
        rem_q   <= ge ? diff[REM_W-1:0] : rem_sh;
        root_q  <= {root_q[POS_W-2:0], ge};
        sq_hi_q <= {sq_hi_q[POS_W-3:0], sq_lo_q[POS_W-1:POS_W-2]};
        sq_lo_q <= {sq_lo_q[POS_W-3:0], 2'b00};
        if (cnt_q < CNT_W'(DEG_K_W)) begin
          g_hi_q <= g_s[HEAD_W:1];
          g_lo_q <= {g_s[0], g_lo_q[DEG_K_W-1:1]};
          gb_q   <= {1'b0, gb_q[DEG_K_W-1:1]};
        end
        if (cnt_q == CNT_W'(DEG_K_W)) begin
          deg_q <= deg_val;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_ok_q               <= ok_q;
          out_data_q.x_pos       <= x_q;
          out_data_q.y_pos       <= y_q;
          out_data_q.heading_rad <= h_q;
          out_data_q.heading_deg <= deg_q;
          out_data_q.distance    <= root_q;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_update_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && primed_q && (s_axis_tuser[0] != mbo_pkg::OP_RESET)) |=> (state_q == ST_PREP))
    else $error("update beat did not start the scaling sequence");

  a_reset_beat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[0] == 1'b0)) |-> (m_axis_tdata == '0))
    else $error("reset beat carries nonzero data");

  a_root_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> (rem_q <= REM_W'({root_q, 1'b0})))
    else $error("square root remainder out of range");

  a_primed_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> primed_q)
    else $error("unit not primed after an input beat");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_FIN))
    else $error("output beat raised outside the finish step");
`endif

endmodule

`default_nettype wire

>>> verif/tb_mecanum_body_odometry_unit.sv
module tb_mecanum_body_odometry_unit;
  import mbo_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned PHASE_BEATS = 158;
  localparam int unsigned TAIL_CYCLES = 150;
  localparam longint unsigned MAG_CLAMP = 64'd1 << 62;

  typedef struct packed {
    logic        ok;
    mbo_result_t data;
  } odo_beat_t;

  typedef enum {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE
  } ready_mode_e;

  class odometry_scoreboard;
    logic                 primed;
    logic [4*COUNT_W-1:0] stored_counts;
    longint               x_mm;
    longint               y_mm;
    longint               heading;
    longint               mm_scale;
    longint               rad_scale;
    odo_beat_t            expected_q[$];
    int unsigned          mismatches;

    function new();
      primed        = 1'b0;
      stored_counts = '0;
      x_mm          = 0;
      y_mm          = 0;
      heading       = 0;
      mm_scale      = longint'(MM_PER_COUNT_RST);
      rad_scale     = longint'(RAD_PER_MM_RST);
      mismatches    = 0;
    endfunction

    function void set_config(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_MM_PER_COUNT) begin
        mm_scale = longint'(value);
      end else if (idx == CFG_RAD_PER_MM) begin
        rad_scale = longint'(value);
      end
    endfunction

    function longint rounded_product(longint a, longint b, int shift);
      logic [127:0] wide;
      logic [63:0]  mag;
      mag  = (a < 0) ? -a : a;
      wide = ({64'd0, mag} * {64'd0, b[63:0]} + (128'd1 << (shift - 1))) >> shift;
      if (wide > {64'd0, MAG_CLAMP}) begin
        wide = {64'd0, MAG_CLAMP};
      end
      return (a < 0) ? -longint'(wide[63:0]) : longint'(wide[63:0]);
    endfunction

    function longint saturate(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) begin
        return hi;
      end
      if (v < -hi - 1) begin
        return -hi - 1;
      end
      return v;
    endfunction

    function logic [63:0] hypotenuse(longint x, longint y);
      logic [127:0] radicand;
      logic [127:0] trial_sq;
      logic [63:0]  ax;
      logic [63:0]  ay;
      logic [63:0]  root;
      logic [63:0]  trial;
      int           k;
      ax       = (x < 0) ? -x : x;
      ay       = (y < 0) ? -y : y;
      radicand = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
      root     = '0;
      for (k = 63; k >= 0; k--) begin
        trial    = root | (64'd1 << k);
        trial_sq = {64'd0, trial} * {64'd0, trial};
        if (trial_sq <= radicand) begin
          root = trial;
        end
      end
      return root;
    endfunction

    function void predict_beat(logic op, logic [4*COUNT_W-1:0] counts);
      odo_beat_t          want;
      longint             wheel_mm[4];
      logic signed [COUNT_W-1:0] delta;
      longint             dx;
      longint             dy;
      longint             dphi;
      longint             deg;
      logic [63:0]        dist_val;
      int                 k;
      want = '0;
      if (!primed || op == OP_RESET) begin
        primed        = 1'b1;
        stored_counts = counts;
        x_mm          = 0;
        y_mm          = 0;
        heading       = 0;
      end else begin
        for (k = 0; k < 4; k++) begin
          delta       = counts[COUNT_W*k +: COUNT_W] - stored_counts[COUNT_W*k +: COUNT_W];
          wheel_mm[k] = longint'(delta) * mm_scale;
        end
        stored_counts = counts;
        dx   = (wheel_mm[0] + wheel_mm[1] + wheel_mm[2] + wheel_mm[3] + 2) >>> 2;
        dy   = (wheel_mm[0] - wheel_mm[1] + wheel_mm[2] - wheel_mm[3] + 2) >>> 2;
        dphi = rounded_product(wheel_mm[0] - wheel_mm[1] - wheel_mm[2] + wheel_mm[3],
                               rad_scale, RAD_SHIFT);
        x_mm    = saturate(x_mm + dx, POS_W);
        y_mm    = saturate(y_mm + dy, POS_W);
        heading = saturate(heading + dphi, HEAD_W);
        deg  = saturate(rounded_product(heading, longint'(DEG_PER_RAD_Q24), DEG_SHIFT), POS_W);
        dist_val = hypotenuse(x_mm, y_mm);
        want.ok               = 1'b1;
        want.data.x_pos       = x_mm[POS_W-1:0];
        want.data.y_pos       = y_mm[POS_W-1:0];
        want.data.heading_rad = heading[HEAD_W-1:0];
        want.data.heading_deg = deg[POS_W-1:0];
        want.data.distance    = dist_val[POS_W-1:0];
      end
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
      end
    endtask

    task check_result(logic ok, mbo_result_t got);
      odo_beat_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("output beat with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      compare_field("ok", 64'(ok), 64'(want.ok));
      compare_field("x_pos", 64'(got.x_pos), 64'(want.data.x_pos));
      compare_field("y_pos", 64'(got.y_pos), 64'(want.data.y_pos));
      compare_field("heading_rad", 64'(got.heading_rad), 64'(want.data.heading_rad));
      compare_field("heading_deg", 64'(got.heading_deg), 64'(want.data.heading_deg));
      compare_field("distance", 64'(got.distance), 64'(want.data.distance));
    endtask

    task finish_check();
      if (expected_q.size() != 0) begin
        report_mismatch($sformatf("%0d expected beats never arrived", expected_q.size()));
      end
    endtask
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [4*COUNT_W-1:0]              s_axis_tdata;
  logic [0:0]                        s_axis_tuser;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [$bits(mbo_result_t)-1:0]    m_axis_tdata;
  logic [0:0]                        m_axis_tuser;
  logic                              cfg_we_i;
  logic [CFG_ADDR_W-1:0]             cfg_addr_i;
  logic [CFG_W-1:0]                  cfg_wdata_i;

  logic                              hold_req = 1'b0;
  logic [4*COUNT_W-1:0]              last_sent = '0;
  int unsigned                       cycle_count = 0;
  odometry_scoreboard                sb = new();

  mecanum_body_odometry_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser[0], mbo_result_t'(m_axis_tdata));
    end
  end

  int unsigned hold_count = 0;
  int unsigned mode_left  = 0;
  ready_mode_e ready_mode = READY_ALWAYS;

  always @(negedge clk_i) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      hold_count++;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(2));
        mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      case (ready_mode)
        READY_ALWAYS: m_axis_tready <= 1'b1;
        READY_HALF:   m_axis_tready <= 1'($urandom_range(1));
        default:      m_axis_tready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("mecanum_body_odometry_unit test failed");
    $finish;
  end

  task automatic send_beat(logic op, logic [4*COUNT_W-1:0] counts);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= counts;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.predict_beat(op, counts);
    last_sent = counts;
  endtask

  task automatic send_deltas(logic op, logic [COUNT_W-1:0] fr, logic [COUNT_W-1:0] fl,
                             logic [COUNT_W-1:0] rl, logic [COUNT_W-1:0] rr);
    logic [4*COUNT_W-1:0] counts;
    counts = {last_sent[3*COUNT_W +: COUNT_W] + rr, last_sent[2*COUNT_W +: COUNT_W] + rl,
              last_sent[COUNT_W +: COUNT_W] + fl, last_sent[0 +: COUNT_W] + fr};
    send_beat(op, counts);
  endtask

  task automatic send_random();
    logic                 op;
    logic [4*COUNT_W-1:0] counts;
    logic [COUNT_W-1:0]   step;
    int unsigned          pick;
    int                   k;
    op   = ($urandom_range(24) == 0) ? OP_RESET : ~OP_RESET;
    pick = $urandom_range(99);
    for (k = 0; k < 4; k++) begin
      if (pick < 70) begin
        step = $urandom_range(4000) - 2000;
      end else if (pick < 90) begin
        step = $urandom_range(1 << 21) - (1 << 20);
      end else begin
        step = $urandom;
      end
      counts[COUNT_W*k +: COUNT_W] = last_sent[COUNT_W*k +: COUNT_W] + step;
    end
    send_beat(op, counts);
  endtask

  task automatic idle(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  task automatic drain();
    idle(1);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_config(idx, value);
  endtask

  task automatic configure(logic [CFG_W-1:0] mm, logic [CFG_W-1:0] rad);
    write_reg(CFG_MM_PER_COUNT, mm);
    write_reg(CFG_RAD_PER_MM, rad);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned beat;
    int unsigned burst_left;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The first beat primes the unit even though op is clear.
    send_beat(~OP_RESET, {32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    send_deltas(~OP_RESET, 0, 0, 0, 0);
    send_deltas(~OP_RESET, 1, 1, 1, 1);
    send_deltas(~OP_RESET, 100, -100, 100, -100);
    send_deltas(~OP_RESET, 100, -100, -100, 100);
    send_deltas(~OP_RESET, -300, 300, 300, -300);
    send_deltas(~OP_RESET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_deltas(~OP_RESET, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_beat(OP_RESET, {$urandom, $urandom, $urandom, $urandom});
    send_deltas(~OP_RESET, -5, -5, -5, -5);

    // Unit scaling exposes the rounding of exact halves.
    drain();
    configure(1, 1);
    send_deltas(~OP_RESET, 2, 0, 0, 0);
    send_deltas(~OP_RESET, -2, 0, 0, 0);
    send_deltas(~OP_RESET, 1, 1, 0, 0);
    send_deltas(~OP_RESET, 0, -2, 0, 0);
    send_deltas(~OP_RESET, 0, 0, 0, 3);

    // Full scale drives x and heading into saturation both ways and y into positive saturation.
    drain();
    configure('1, '1);
    send_deltas(~OP_RESET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_deltas(~OP_RESET, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_deltas(~OP_RESET, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_deltas(~OP_RESET, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_deltas(~OP_RESET, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);

    drain();
    configure('0, '0);
    send_deltas(~OP_RESET, $urandom, $urandom, $urandom, $urandom);
    send_beat(OP_RESET, {$urandom, $urandom, $urandom, $urandom});

    for (phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0:       configure(MM_PER_COUNT_RST, RAD_PER_MM_RST);
        1:       configure($urandom, $urandom);
        2:       configure('1, '1);
        3:       configure($urandom_range(1, 1 << 18), $urandom_range(1, 1 << 18));
        4:       configure('0, '0);
        default: configure($urandom, $urandom);
      endcase
      if (phase == 1) begin
        hold_req = 1'b1;
      end
      burst_left = 0;
      for (beat = 0; beat < PHASE_BEATS; beat++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if ($urandom_range(3) != 0) begin
            idle($urandom_range(1, 8));
          end
        end
        send_random();
        burst_left--;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.finish_check();
    if (sb.mismatches == 0) begin
      $display("mecanum_body_odometry_unit test passed");
    end else begin
      $display("mecanum_body_odometry_unit test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mbo_pkg.sv
src/mecanum_body_odometry_unit.sv
verif/tb_mecanum_body_odometry_unit.sv
